// File: rtl/mhp_pkg.sv
package mhp_pkg;

   localparam int WORDS_PER_ROW = 16;
   localparam int ROW_INDEX_WIDTH = 17;

   localparam int QUERY_DEPTH = 16;
   localparam int QUERY_INDEX_WIDTH = 4;
   localparam int DATA_WIDTH = 64;
   localparam int WORD_POP_WIDTH = 7;
   localparam int MASK_ONES_WIDTH = 11;
   localparam int MISMATCH_WIDTH = 11;
   localparam int SCORE_WIDTH = 13;
   localparam int SCORE_CALC_WIDTH = 15;
   localparam int ROW_NUMBER_WIDTH = 17;
   localparam int POS_WIDTH = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = 1;
   localparam int QUEUE_COUNT_WIDTH = 2;

   localparam logic CMD_LOAD = 1'b0;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_ROW  = 1'b1
   } op_type;

   typedef struct packed {
      op_type                         op;
      logic [QUERY_INDEX_WIDTH-1:0]   word_index;
      logic [DATA_WIDTH-1:0]          data_word;
      logic [DATA_WIDTH-1:0]          mask_word;
      logic [WORD_POP_WIDTH-1:0]      mask_pop;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [WORD_POP_WIDTH-1:0] pop64(input logic [DATA_WIDTH-1:0] v);
      logic [WORD_POP_WIDTH-1:0] n;
      n = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         n = n + WORD_POP_WIDTH'(v[i]);
      end
      return n;
   endfunction

endpackage

// File: rtl/mhp_req_if.sv
interface mhp_req_if import mhp_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [QUERY_INDEX_WIDTH-1:0] word_index;
   logic [DATA_WIDTH-1:0]        data_word;
   logic [DATA_WIDTH-1:0]        mask_word;

   modport source (output valid, output command, output word_index, output data_word,
                   output mask_word, input ready);
   modport sink (input valid, input command, input word_index, input data_word,
                 input mask_word, output ready);
endinterface

// File: rtl/mhp_rsp_if.sv
interface mhp_rsp_if import mhp_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic signed [SCORE_WIDTH-1:0] score;
   logic                        matched;
   logic [ROW_NUMBER_WIDTH-1:0] row_number;

   modport source (output valid, output score, output matched, output row_number,
                   input ready);
   modport sink (input valid, input score, input matched, input row_number,
                 output ready);
endinterface

// File: rtl/masked_hamming_prefilter.sv
// One request is accepted per cycle unless the queue is full; a result is registered per row.
// The back end's single popcount and accumulate take one 64-bit word per cycle unless stalled.
// The mask popcount of a query load is taken in the front end and applied incrementally.
// Synchronous active-high reset clears the query present bits, counters, queue and result valid.
// After reset the block accepts requests in the next cycle.
module masked_hamming_prefilter import mhp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mhp_req_if.sink   req_chan,
   mhp_rsp_if.source rsp_chan
);

   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head_entry;
   queue_status_type qstat;

   mhp_front u_front (
      .req_chan   (req_chan),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   mhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   mhp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: rtl/mhp_front.sv
module mhp_front import mhp_pkg::*; (
   mhp_req_if.sink          req_chan,
   input  queue_status_type qstat,
   output logic             push,
   output entry_type        push_entry
);

   always_comb begin
      req_chan.ready = !qstat.full;
      push = req_chan.valid && !qstat.full;

      push_entry.word_index = req_chan.word_index;
      push_entry.data_word = req_chan.data_word;
      push_entry.mask_word = req_chan.mask_word;
      push_entry.mask_pop = '0;
      case (req_chan.command)
         CMD_LOAD: begin
            push_entry.op = OP_LOAD;
            push_entry.mask_pop = pop64(req_chan.mask_word);
         end
         default: begin
            push_entry.op = OP_ROW;
         end
      endcase
   end

endmodule

// File: rtl/mhp_queue.sv
module mhp_queue import mhp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type qstat
);

   entry_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      qstat.full = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
      qstat.empty = (count_ff == '0);
      head_entry = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/mhp_back.sv
module mhp_back import mhp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head_entry,
   input  queue_status_type qstat,
   output logic             pop,
   mhp_rsp_if.source        rsp_chan
);

   localparam logic signed [SCORE_CALC_WIDTH-1:0] SCORE_MAX = SCORE_CALC_WIDTH'(4095);
   localparam logic signed [SCORE_CALC_WIDTH-1:0] SCORE_MIN = -SCORE_CALC_WIDTH'(4096);
   localparam logic [POS_WIDTH-1:0] LAST_POS = POS_WIDTH'(WORDS_PER_ROW - 1);

   logic [DATA_WIDTH-1:0]      sign_ff [QUERY_DEPTH];
   logic [DATA_WIDTH-1:0]      mask_ff [QUERY_DEPTH];
   logic [WORD_POP_WIDTH-1:0]  pop_ff [QUERY_DEPTH];
   logic [QUERY_DEPTH-1:0]     present_ff, present_in;

   logic [MASK_ONES_WIDTH-1:0]  mask_ones_ff, mask_ones_in;
   logic [POS_WIDTH-1:0]        pos_ff, pos_in;
   logic [MISMATCH_WIDTH-1:0]   mismatch_ff, mismatch_in;
   logic [ROW_INDEX_WIDTH-1:0]  row_ff, row_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_WIDTH-1:0] score_ff, score_in;
   logic                          matched_ff, matched_in;
   logic [ROW_NUMBER_WIDTH-1:0]   row_number_ff, row_number_in;

   logic                           store_wr;
   logic [QUERY_INDEX_WIDTH-1:0]   slot;
   logic [DATA_WIDTH-1:0]          slot_sign;
   logic [DATA_WIDTH-1:0]          slot_mask;
   logic [WORD_POP_WIDTH-1:0]      old_pop;
   logic [WORD_POP_WIDTH-1:0]      diff_pop;
   logic [MISMATCH_WIDTH:0]        sum_wide;
   logic [MISMATCH_WIDTH-1:0]      sum_sat;
   logic signed [SCORE_CALC_WIDTH-1:0] score_wide;
   logic signed [SCORE_WIDTH-1:0]  score_clamped;

   always_comb begin
      pop = !qstat.empty && (!rsp_valid_ff || rsp_chan.ready);

      slot = QUERY_INDEX_WIDTH'(pos_ff);
      slot_sign = present_ff[slot] ? sign_ff[slot] : '0;
      slot_mask = present_ff[slot] ? mask_ff[slot] : '0;
      old_pop = present_ff[head_entry.word_index] ? pop_ff[head_entry.word_index] : '0;

      diff_pop = pop64((head_entry.data_word ^ slot_sign) & slot_mask);
      sum_wide = {1'b0, mismatch_ff} + (MISMATCH_WIDTH + 1)'(diff_pop);
      sum_sat = sum_wide[MISMATCH_WIDTH] ? '1 : sum_wide[MISMATCH_WIDTH-1:0];

      score_wide = $signed({3'b000, mask_ones_ff, 1'b0})
                 - $signed({2'b00, sum_sat, 2'b00});
      if (score_wide > SCORE_MAX) begin
         score_clamped = SCORE_MAX[SCORE_WIDTH-1:0];
      end else if (score_wide < SCORE_MIN) begin
         score_clamped = SCORE_MIN[SCORE_WIDTH-1:0];
      end else begin
         score_clamped = score_wide[SCORE_WIDTH-1:0];
      end
   end

   always_comb begin
      store_wr = 1'b0;
      present_in = present_ff;
      mask_ones_in = mask_ones_ff;
      pos_in = pos_ff;
      mismatch_in = mismatch_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      score_in = score_ff;
      matched_in = matched_ff;
      row_number_in = row_number_ff;

      if (pop) begin
         case (head_entry.op)
            OP_LOAD: begin
               store_wr = 1'b1;
               present_in[head_entry.word_index] = 1'b1;
               if (32'(head_entry.word_index) < WORDS_PER_ROW) begin
                  mask_ones_in = mask_ones_ff - MASK_ONES_WIDTH'(old_pop)
                               + MASK_ONES_WIDTH'(head_entry.mask_pop);
               end
               pos_in = '0;
               mismatch_in = '0;
               row_in = '0;
            end
            default: begin
               if (pos_ff == LAST_POS) begin
                  rsp_valid_in = 1'b1;
                  score_in = score_clamped;
                  matched_in = (sum_sat == '0);
                  row_number_in = ROW_NUMBER_WIDTH'(row_ff);
                  row_in = row_ff + 1'b1;
                  pos_in = '0;
                  mismatch_in = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  mismatch_in = sum_sat;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         mask_ones_ff <= '0;
         pos_ff <= '0;
         mismatch_ff <= '0;
         row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff <= present_in;
         mask_ones_ff <= mask_ones_in;
         pos_ff <= pos_in;
         mismatch_ff <= mismatch_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      matched_ff <= matched_in;
      row_number_ff <= row_number_in;
      if (store_wr) begin
         sign_ff[head_entry.word_index] <= head_entry.data_word;
         mask_ff[head_entry.word_index] <= head_entry.mask_word;
         pop_ff[head_entry.word_index] <= head_entry.mask_pop;
      end
   end

   always_comb begin
      rsp_chan.valid = rsp_valid_ff;
      rsp_chan.score = score_ff;
      rsp_chan.matched = matched_ff;
      rsp_chan.row_number = row_number_ff;
   end

endmodule

// File: test/mhp_row_checker.sv
module mhp_row_checker import mhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mhp_req_if          req_chan,
   mhp_rsp_if          rsp_chan,
   output int unsigned failures,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MISMATCH_LIMIT = (1 << MISMATCH_WIDTH) - 1;
   localparam int SCORE_TOP = (1 << (SCORE_WIDTH - 1)) - 1;
   localparam int SCORE_BOTTOM = -(1 << (SCORE_WIDTH - 1));

   typedef struct packed {
      logic signed [SCORE_WIDTH-1:0] score;
      logic                          matched;
      logic [ROW_NUMBER_WIDTH-1:0]   row_number;
   } row_score_type;

   logic [DATA_WIDTH-1:0]      sign_store [QUERY_DEPTH];
   logic [DATA_WIDTH-1:0]      mask_store [QUERY_DEPTH];
   int                         mask_bits;
   int                         position;
   int                         mismatches;
   logic [ROW_INDEX_WIDTH-1:0] row_index;
   row_score_type              expected_scores [$];

   function automatic void clear_query();
      for (int w = 0; w < QUERY_DEPTH; w++) begin
         sign_store[w] = '0;
         mask_store[w] = '0;
      end
      mask_bits = 0;
      position = 0;
      mismatches = 0;
      row_index = '0;
      expected_scores.delete();
   endfunction

   function automatic void score_request(input logic cmd, input logic [QUERY_INDEX_WIDTH-1:0] idx,
                                         input logic [DATA_WIDTH-1:0] data,
                                         input logic [DATA_WIDTH-1:0] mask);
      int            total;
      int            slot;
      int            score_full;
      row_score_type row_score;
      if (op_type'(cmd) == OP_LOAD) begin
         sign_store[idx] = data;
         mask_store[idx] = mask;
         total = 0;
         for (int w = 0; w < QUERY_DEPTH && w < WORDS_PER_ROW; w++) begin
            total += $countones(mask_store[w]);
         end
         mask_bits = total % (1 << MASK_ONES_WIDTH);
         position = 0;
         mismatches = 0;
         row_index = '0;
      end else begin
         slot = position % QUERY_DEPTH;
         total = mismatches + $countones((data ^ sign_store[slot]) & mask_store[slot]);
         mismatches = (total > MISMATCH_LIMIT) ? MISMATCH_LIMIT : total;
         position++;
         if (position >= WORDS_PER_ROW) begin
            score_full = 2 * mask_bits - 4 * mismatches;
            if (score_full > SCORE_TOP) begin
               score_full = SCORE_TOP;
            end
            if (score_full < SCORE_BOTTOM) begin
               score_full = SCORE_BOTTOM;
            end
            row_score.score = score_full[SCORE_WIDTH-1:0];
            row_score.matched = (mismatches == 0);
            row_score.row_number = ROW_NUMBER_WIDTH'(row_index);
            expected_scores.push_back(row_score);
            row_index = row_index + 1'b1;
            position = 0;
            mismatches = 0;
         end
      end
   endfunction

   function automatic void compare_result();
      row_score_type want;
      if (expected_scores.size() == 0) begin
         $error("unexpected result: score %0d, matched %0d, row_number %0d",
                rsp_chan.score, rsp_chan.matched, rsp_chan.row_number);
         failures++;
      end else begin
         want = expected_scores.pop_front();
         if (rsp_chan.score !== want.score) begin
            $error("score: expected %0d, actual %0d", want.score, rsp_chan.score);
            failures++;
         end
         if (rsp_chan.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, rsp_chan.matched);
            failures++;
         end
         if (rsp_chan.row_number !== want.row_number) begin
            $error("row_number: expected %0d, actual %0d", want.row_number,
                   rsp_chan.row_number);
            failures++;
         end
      end
   endfunction

   initial begin
      failures = 0;
      pending = 0;
      clear_query();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_query();
      end else begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            score_request(req_chan.command, req_chan.word_index, req_chan.data_word,
                          req_chan.mask_word);
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            compare_result();
         end
      end
      pending = expected_scores.size();
   end

endmodule

// File: test/tb_masked_hamming_prefilter.sv
module tb_masked_hamming_prefilter import mhp_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      ROW_EXACT,
      ROW_MASKED,
      ROW_NEAR,
      ROW_RANDOM,
      ROW_INVERTED
   } row_style_type;

   typedef enum int {
      MASK_FULL,
      MASK_EMPTY,
      MASK_RANDOM,
      MASK_SPARSE
   } mask_kind_type;

   logic                  clock;
   logic                  reset;
   int unsigned           failures;
   int unsigned           pending;
   bit                    calm;
   int unsigned           requests_sent;
   int unsigned           row_pos;
   logic [DATA_WIDTH-1:0] sign_copy [QUERY_DEPTH];
   logic [DATA_WIDTH-1:0] mask_copy [QUERY_DEPTH];

   mhp_req_if req_chan ();
   mhp_rsp_if rsp_chan ();

   masked_hamming_prefilter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   mhp_row_checker row_check (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #500us;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned wait_cycles();
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [DATA_WIDTH-1:0] make_sign();
      case ($urandom_range(0, 5))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return random_word();
         end
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] make_mask(input mask_kind_type kind);
      case (kind)
         MASK_FULL: begin
            return '1;
         end
         MASK_EMPTY: begin
            return '0;
         end
         MASK_SPARSE: begin
            return random_word() & random_word() & random_word();
         end
         default: begin
            return random_word();
         end
      endcase
   endfunction

   task automatic send_request(input op_type cmd, input logic [QUERY_INDEX_WIDTH-1:0] idx,
                               input logic [DATA_WIDTH-1:0] data,
                               input logic [DATA_WIDTH-1:0] mask);
      int unsigned hold;
      hold = wait_cycles();
      if (hold > 0) begin
         req_chan.valid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.word_index <= idx;
      req_chan.data_word <= data;
      req_chan.mask_word <= mask;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      requests_sent++;
      if (cmd == OP_LOAD) begin
         sign_copy[idx] = data;
         mask_copy[idx] = mask;
         row_pos = 0;
      end else begin
         row_pos = (row_pos + 1) % WORDS_PER_ROW;
      end
   endtask

   task automatic load_word(input logic [QUERY_INDEX_WIDTH-1:0] idx,
                            input logic [DATA_WIDTH-1:0] sign, input logic [DATA_WIDTH-1:0] mask);
      send_request(OP_LOAD, idx, sign, mask);
   endtask

   task automatic send_row_word(input logic [DATA_WIDTH-1:0] data);
      send_request(OP_ROW, QUERY_INDEX_WIDTH'($urandom_range(0, QUERY_DEPTH - 1)), data,
                   random_word());
   endtask

   task automatic send_row(input row_style_type style);
      int unsigned           slot;
      logic [DATA_WIDTH-1:0] data;
      for (int w = 0; w < WORDS_PER_ROW; w++) begin
         slot = row_pos % QUERY_DEPTH;
         case (style)
            ROW_EXACT: begin
               data = sign_copy[slot];
            end
            ROW_MASKED: begin
               data = sign_copy[slot] ^ (random_word() & ~mask_copy[slot]);
            end
            ROW_NEAR: begin
               data = sign_copy[slot];
               if ($urandom_range(0, 3) == 0) begin
                  data[$urandom_range(0, DATA_WIDTH - 1)] ^= 1'b1;
               end
            end
            ROW_INVERTED: begin
               data = ~sign_copy[slot];
            end
            default: begin
               data = random_word();
            end
         endcase
         send_row_word(data);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int unsigned hold;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = wait_cycles();
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) @(posedge clock);
      end
   end

   initial begin
      int unsigned   pick;
      mask_kind_type kind;
      calm = 1'b0;
      requests_sent = 0;
      row_pos = 0;
      for (int w = 0; w < QUERY_DEPTH; w++) begin
         sign_copy[w] = '0;
         mask_copy[w] = '0;
      end
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.command <= OP_ROW;
      req_chan.word_index <= '0;
      req_chan.data_word <= '0;
      req_chan.mask_word <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Mismatches at both ends of a row, then a row cut short by a load.
      load_word(QUERY_INDEX_WIDTH'(QUERY_DEPTH - 1), '1, '1);
      load_word('0, '0, '1);
      send_row_word('1);
      for (int w = 1; w < WORDS_PER_ROW - 1; w++) begin
         send_row_word(random_word());
      end
      send_row_word('0);
      for (int w = 0; w < 3; w++) begin
         send_row_word(random_word());
      end
      load_word(QUERY_INDEX_WIDTH'(7), random_word(), '0);
      send_row(ROW_EXACT);
      drain();

      while (requests_sent < 400) begin
         calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            kind = ($urandom_range(0, 1) == 0) ? MASK_FULL : mask_kind_type'($urandom_range(0, 3));
            for (int w = 0; w < QUERY_DEPTH; w++) begin
               load_word(QUERY_INDEX_WIDTH'(w), make_sign(), make_mask(kind));
            end
         end else if (pick < 20) begin
            repeat ($urandom_range(1, 3)) begin
               load_word(QUERY_INDEX_WIDTH'($urandom_range(0, QUERY_DEPTH - 1)), make_sign(),
                         make_mask(mask_kind_type'($urandom_range(0, 3))));
            end
         end else if (pick < 27) begin
            repeat ($urandom_range(1, WORDS_PER_ROW - 1)) begin
               send_row_word(random_word());
            end
            if ($urandom_range(0, 2) != 0) begin
               load_word(QUERY_INDEX_WIDTH'($urandom_range(0, QUERY_DEPTH - 1)), make_sign(),
                         make_mask(mask_kind_type'($urandom_range(0, 3))));
            end
         end else begin
            send_row(row_style_type'($urandom_range(0, 4)));
         end
         if ($urandom_range(0, 19) == 0) begin
            drain();
         end
      end

      calm = 1'b0;
      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
